@@ hw/rtl/fbfla_pkg.sv @@
// fbfla_pkg: shared types and constants of the fixed block free list allocator
// sequencer state type, status and opcode codes, config register indexes, field widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbfla_pkg;

  // fixed field widths of the ports
  localparam int OPC_W      = 1;
  localparam int OFF_W      = 22;
  localparam int IDX_OUT_W  = 10;
  localparam int BYTES_OUT_W = 13;
  localparam int STAT_W     = 2;
  localparam int SIZE_W     = 13;
  localparam int COUNT_W    = 11;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;

  // register reset values
  localparam logic [SIZE_W-1:0]  SIZE_RST  = 13'd64;
  localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  // opcodes
  localparam logic [OPC_W-1:0] OP_ALLOC   = 1'b0;
  localparam logic [OPC_W-1:0] OP_RELEASE = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ALIGN = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RND_MUL,
    S_RND_QA,
    S_RND_FIX,
    S_ALLOC,
    S_ALLOC_END,
    S_REL_RANGE,
    S_REL_CHK,
    S_REL_DIV,
    S_REL_END,
    S_OUT
  } fbfla_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/fixed_block_free_list_allocator.sv @@
// fixed_block_free_list_allocator: pool of equal blocks with a lifo free list
// allocate: size rounding, pop of the released stack or next fresh block, result;
// out of memory goes to the result straight from the pick; release: size rounding, range
// check, 10-step shift-subtract divider, alignment check and push, result; out of range skips the divider
// throughput: one item at a time, next item taken the cycle after the result is taken
// reset: block_size 64, block_count 1024, free list empty, link memory not cleared
// depends on fbfla_pkg
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list_allocator
  import fbfla_pkg::*;
#(
  parameter int MAX_BLOCKS      = 1024,
  parameter int ALIGN_BYTES     = 8,
  parameter int MAX_BLOCK_BYTES = 4096
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // configuration port
  input  wire                    cfg_we,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_W-1:0]        cfg_wdata,
  // input channel
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire [OPC_W-1:0]        in_opcode,
  input  wire [OFF_W-1:0]        in_release_offset,
  // result channel
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic [STAT_W-1:0]      out_status,
  output logic [OFF_W-1:0]       out_block_offset,
  output logic [IDX_OUT_W-1:0]   out_block_index,
  output logic [BYTES_OUT_W-1:0] out_block_bytes
);

  // derived widths
  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int HEAD_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CNT_W   = HEAD_W;
  localparam int S_W     = (SIZE_W > $clog2(MAX_BLOCK_BYTES + 1)) ? SIZE_W
                                                                  : $clog2(MAX_BLOCK_BYTES + 1);
  localparam int CC_W    = (COUNT_W > CNT_W) ? COUNT_W : CNT_W;
  localparam int X_W     = $clog2(MAX_BLOCK_BYTES + ALIGN_BYTES);
  localparam int BYTES_W = X_W;
  localparam int K       = X_W;
  localparam int RECIP   = (2 ** K) / ALIGN_BYTES;
  localparam int M_W0    = ((X_W + 1) > HEAD_W) ? (X_W + 1) : HEAD_W;
  localparam int M_W     = (M_W0 > BYTES_W) ? M_W0 : BYTES_W;
  localparam int P_W     = 2 * M_W;
  localparam int CMP_W   = (P_W > OFF_W) ? P_W : OFF_W;
  localparam int D_W     = BYTES_W + IDX_W;
  localparam int W       = (OFF_W > D_W) ? OFF_W : D_W;
  localparam int STEP_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(MAX_BLOCKS);

  // control registers
  fbfla_state_t        state_r, state_nxt;
  logic [SIZE_W-1:0]   block_size_r, block_size_nxt;
  logic [COUNT_W-1:0]  block_count_r, block_count_nxt;
  logic [HEAD_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]    fresh_r, fresh_nxt;

  // payload registers
  logic [OPC_W-1:0]    op_r, op_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [P_W-1:0]      prod_r;
  logic [OFF_W-1:0]    rem_r, rem_nxt;
  logic [D_W-1:0]      div_r, div_nxt;
  logic [IDX_W-1:0]    quo_r, quo_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                pop_r, pop_nxt;
  logic [HEAD_W-1:0]   idx_r, idx_nxt;
  logic [STAT_W-1:0]      stat_r, stat_nxt;
  logic [OFF_W-1:0]       boff_r, boff_nxt;
  logic [IDX_OUT_W-1:0]   bidx_r, bidx_nxt;
  logic [BYTES_OUT_W-1:0] bbytes_r, bbytes_nxt;

  // shared multiplier
  logic [M_W-1:0]      mul_a, mul_b;
  logic [P_W-1:0]      mul_p;

  // link memory
  logic [HEAD_W-1:0]   link_mem [MAX_BLOCKS];
  logic [HEAD_W-1:0]   link_rd_r;
  logic                mem_re;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_addr;
  logic [HEAD_W-1:0]   mem_wd;

  // clamped configuration
  logic [S_W-1:0]      size_cl;
  logic [CC_W-1:0]     count_ext;
  logic [CNT_W-1:0]    count;
  logic [X_W-1:0]      x_val;

  // clamp size and count, form size plus alignment minus one
  always_comb begin
    size_cl = S_W'(block_size_r);
    if (size_cl == '0) begin
      size_cl = S_W'(1);
    end else if (size_cl > S_W'(MAX_BLOCK_BYTES)) begin
      size_cl = S_W'(MAX_BLOCK_BYTES);
    end
    x_val = X_W'(size_cl) + X_W'(ALIGN_BYTES - 1);

    count_ext = CC_W'(block_count_r);
    if (count_ext == '0) begin
      count_ext = CC_W'(1);
    end else if (count_ext > CC_W'(MAX_BLOCKS)) begin
      count_ext = CC_W'(MAX_BLOCKS);
    end
    count = CNT_W'(count_ext);
  end

  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  // handshake
  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_status       = stat_r;
  assign out_block_offset = boff_r;
  assign out_block_index  = bidx_r;
  assign out_block_bytes  = bbytes_r;

  // sequencer: next state, datapath control
  always_comb begin
    logic [X_W-1:0] rnd_rem;
    logic           ge;
    state_nxt       = state_r;
    block_size_nxt  = block_size_r;
    block_count_nxt = block_count_r;
    head_nxt        = head_r;
    fresh_nxt       = fresh_r;
    op_nxt          = op_r;
    off_nxt         = off_r;
    bytes_nxt       = bytes_r;
    rem_nxt         = rem_r;
    div_nxt         = div_r;
    quo_nxt         = quo_r;
    step_nxt        = step_r;
    pop_nxt         = pop_r;
    idx_nxt         = idx_r;
    stat_nxt        = stat_r;
    boff_nxt        = boff_r;
    bidx_nxt        = bidx_r;
    bbytes_nxt      = bbytes_r;
    mul_a           = '0;
    mul_b           = '0;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    mem_addr        = quo_r;
    mem_wd          = head_r;
    rnd_rem         = '0;
    ge              = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          off_nxt   = in_release_offset;
          state_nxt = S_RND_MUL;
        end
      end
      // quotient estimate of (size + align - 1) / align by reciprocal
      S_RND_MUL: begin
        mul_a     = M_W'(x_val);
        mul_b     = M_W'(RECIP);
        state_nxt = S_RND_QA;
      end
      S_RND_QA: begin
        mul_a     = M_W'(prod_r[K +: X_W]);
        mul_b     = M_W'(ALIGN_BYTES);
        state_nxt = S_RND_FIX;
      end
      // remainder with one correction step, rounded size
      S_RND_FIX: begin
        rnd_rem = x_val - prod_r[X_W-1:0];
        if (rnd_rem >= X_W'(ALIGN_BYTES)) begin
          rnd_rem = rnd_rem - X_W'(ALIGN_BYTES);
        end
        bytes_nxt  = x_val - rnd_rem;
        bbytes_nxt = BYTES_OUT_W'(x_val - rnd_rem);
        state_nxt  = (op_r == OP_ALLOC) ? S_ALLOC : S_REL_RANGE;
      end
      // pop released stack, else take next fresh block, else out of memory
      S_ALLOC: begin
        mul_b = M_W'(bytes_r);
        if (CNT_W'(head_r) < count) begin
          pop_nxt   = 1'b1;
          idx_nxt   = head_r;
          mem_re    = 1'b1;
          mem_addr  = IDX_W'(head_r);
          mul_a     = M_W'(head_r);
          state_nxt = S_ALLOC_END;
        end else if (fresh_r < count) begin
          pop_nxt   = 1'b0;
          idx_nxt   = HEAD_W'(fresh_r);
          fresh_nxt = fresh_r + CNT_W'(1);
          mul_a     = M_W'(fresh_r);
          state_nxt = S_ALLOC_END;
        end else begin
          stat_nxt  = STAT_OOM;
          boff_nxt  = '0;
          bidx_nxt  = '0;
          state_nxt = S_OUT;
        end
      end
      S_ALLOC_END: begin
        if (pop_r) begin
          head_nxt = link_rd_r;
        end
        stat_nxt  = STAT_OK;
        boff_nxt  = OFF_W'(prod_r);
        bidx_nxt  = IDX_OUT_W'(idx_r);
        state_nxt = S_OUT;
      end
      // pool size for the range check
      S_REL_RANGE: begin
        mul_a     = M_W'(count);
        mul_b     = M_W'(bytes_r);
        state_nxt = S_REL_CHK;
      end
      S_REL_CHK: begin
        if (CMP_W'(off_r) >= CMP_W'(prod_r)) begin
          stat_nxt  = STAT_RANGE;
          boff_nxt  = '0;
          bidx_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          rem_nxt   = off_r;
          div_nxt   = D_W'(bytes_r) << (IDX_W - 1);
          quo_nxt   = '0;
          step_nxt  = STEP_W'(IDX_W - 1);
          state_nxt = S_REL_DIV;
        end
      end
      // one quotient bit per cycle, shift-subtract
      S_REL_DIV: begin
        ge = (W'(rem_r) >= W'(div_r));
        if (ge) begin
          rem_nxt = OFF_W'(W'(rem_r) - W'(div_r));
        end
        quo_nxt = IDX_W'({quo_r, ge});
        div_nxt = div_r >> 1;
        if (step_r == '0) begin
          state_nxt = S_REL_END;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      // alignment check, push on released stack
      S_REL_END: begin
        boff_nxt = '0;
        if (rem_r != '0) begin
          stat_nxt = STAT_ALIGN;
          bidx_nxt = '0;
        end else begin
          mem_we   = 1'b1;
          mem_addr = quo_r;
          mem_wd   = head_r;
          head_nxt = HEAD_W'(quo_r);
          stat_nxt = STAT_OK;
          bidx_nxt = IDX_OUT_W'(quo_r);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // config write rebuilds the pool
    if (cfg_we) begin
      head_nxt  = EMPTY_MARK;
      fresh_nxt = '0;
      case (cfg_index)
        CFG_BLOCK_SIZE:  block_size_nxt  = cfg_wdata[SIZE_W-1:0];
        CFG_BLOCK_COUNT: block_count_nxt = cfg_wdata[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      block_size_r  <= SIZE_RST;
      block_count_r <= COUNT_RST;
      head_r        <= EMPTY_MARK;
      fresh_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      block_size_r  <= block_size_nxt;
      block_count_r <= block_count_nxt;
      head_r        <= head_nxt;
      fresh_r       <= fresh_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    off_r    <= off_nxt;
    bytes_r  <= bytes_nxt;
    prod_r   <= mul_p;
    rem_r    <= rem_nxt;
    div_r    <= div_nxt;
    quo_r    <= quo_nxt;
    step_r   <= step_nxt;
    pop_r    <= pop_nxt;
    idx_r    <= idx_nxt;
    stat_r   <= stat_nxt;
    boff_r   <= boff_nxt;
    bidx_r   <= bidx_nxt;
    bbytes_r <= bbytes_nxt;
  end

  // link memory, one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_addr] <= mem_wd;
    end
    if (mem_re) begin
      link_rd_r <= link_mem[mem_addr];
    end
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking testbench for the fixed block free list allocator
// directed table, then randomized phases checked by a built-in pool predictor
// depends on fbfla_pkg and fixed_block_free_list_allocator
`timescale 1ns / 1ps

module tb;
  import fbfla_pkg::*;

  localparam int MAX_BLOCKS        = 1024;
  localparam int ALIGN_BYTES       = 8;
  localparam int MAX_BLOCK_BYTES   = 4096;
  localparam int EMPTY_MARK        = MAX_BLOCKS;
  localparam int OFF_LIMIT         = (1 << OFF_W) - 1;
  localparam int CFG_SETTLE_CYCLES = 20;
  localparam int DRAIN_CYCLES      = 40;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int NUM_PHASES        = 8;
  localparam int PHASE_ITEMS       = 244;
  localparam int NUM_DIR           = 30;

  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [OFF_W-1:0]       offset;
    logic [IDX_OUT_W-1:0]   index;
    logic [BYTES_OUT_W-1:0] bytes;
  } alloc_result_t;

  typedef enum logic [0:0] {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_val;
    logic [OPC_W-1:0]     op;
    logic [OFF_W-1:0]     off;
    logic                 typed;
    alloc_result_t        res;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n             = 1'b0;
  logic                   cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index         = CFG_BLOCK_SIZE;
  logic [CFG_W-1:0]       cfg_wdata         = '0;
  logic                   in_valid          = 1'b0;
  logic                   in_stall;
  logic [OPC_W-1:0]       in_opcode         = OP_ALLOC;
  logic [OFF_W-1:0]       in_release_offset = '0;
  logic                   out_valid;
  logic                   out_stall         = 1'b0;
  logic [STAT_W-1:0]      out_status;
  logic [OFF_W-1:0]       out_block_offset;
  logic [IDX_OUT_W-1:0]   out_block_index;
  logic [BYTES_OUT_W-1:0] out_block_bytes;

  fixed_block_free_list_allocator #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .ALIGN_BYTES     (ALIGN_BYTES),
    .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_release_offset (in_release_offset),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_offset  (out_block_offset),
    .out_block_index   (out_block_index),
    .out_block_bytes   (out_block_bytes)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // pool model: settings, link memory, released stack head, fresh pointer
  logic [SIZE_W-1:0]  pool_size_reg;
  logic [COUNT_W-1:0] pool_count_reg;
  int                 link_mem [MAX_BLOCKS];
  int                 stack_head;
  int                 fresh_next;

  alloc_result_t pending_results [$];
  int            granted_offsets [$];
  alloc_result_t oldest;
  int            idle_pct     = 0;
  int            stall_pct    = 0;
  int            n_fail       = 0;
  int            quiet_cycles = 0;

  function automatic int block_bytes_eff();
    int s;
    s = pool_size_reg;
    if (s < 1) s = 1;
    if (s > MAX_BLOCK_BYTES) s = MAX_BLOCK_BYTES;
    return ((s + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  function automatic int block_count_eff();
    int c;
    c = pool_count_reg;
    if (c < 1) c = 1;
    if (c > MAX_BLOCKS) c = MAX_BLOCKS;
    return c;
  endfunction

  // one request against the pool model
  function automatic alloc_result_t serve_request(input logic [OPC_W-1:0] op,
                                                  input logic [OFF_W-1:0] off);
    alloc_result_t res;
    int bytes, count, idx;
    bytes = block_bytes_eff();
    count = block_count_eff();
    res = '0;
    res.bytes = bytes[BYTES_OUT_W-1:0];
    if (op == OP_ALLOC) begin
      if (stack_head < count) begin
        idx = stack_head;
        stack_head = link_mem[idx];
        res.index = idx[IDX_OUT_W-1:0];
        res.offset = OFF_W'(idx * bytes);
      end else if (fresh_next < count) begin
        idx = fresh_next;
        fresh_next++;
        res.index = idx[IDX_OUT_W-1:0];
        res.offset = OFF_W'(idx * bytes);
      end else begin
        res.status = STAT_OOM;
      end
    end else begin
      if (int'(off) >= bytes * count) begin
        res.status = STAT_RANGE;
      end else if (int'(off) % bytes != 0) begin
        res.status = STAT_ALIGN;
      end else begin
        idx = int'(off) / bytes;
        link_mem[idx] = stack_head;
        stack_head = idx;
        res.index = idx[IDX_OUT_W-1:0];
      end
    end
    return res;
  endfunction

  // register writes rebuild the pool
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BLOCK_SIZE) pool_size_reg = val[SIZE_W-1:0];
    else pool_count_reg = val[COUNT_W-1:0];
    stack_head = EMPTY_MARK;
    fresh_next = 0;
    granted_offsets.delete();
  endtask

  // offer one item, hold it until taken, then record its expected result
  task automatic send_item(input logic [OPC_W-1:0] op, input logic [OFF_W-1:0] off,
                           input logic use_typed, input alloc_result_t typed_res,
                           output alloc_result_t got);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_release_offset <= off;
    do @(posedge clk); while (in_stall);
    got = serve_request(op, off);
    pending_results.push_back(use_typed ? typed_res : got);
  endtask

  // directed items; expected values given only where they are obvious
  stim_row_t dir_rows [NUM_DIR] = '{
    // reset settings: 64-byte blocks, 1024 of them
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b1, '{STAT_OK, 22'd0, 10'd0, 13'd64}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b1, '{STAT_OK, 22'd64, 10'd1, 13'd64}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd64, 1'b1,
      '{STAT_OK, 22'd0, 10'd1, 13'd64}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b1, '{STAT_OK, 22'd64, 10'd1, 13'd64}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd65536, 1'b1,
      '{STAT_RANGE, 22'd0, 10'd0, 13'd64}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'h3FFFFF, 1'b1,
      '{STAT_RANGE, 22'd0, 10'd0, 13'd64}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd65535, 1'b1,
      '{STAT_ALIGN, 22'd0, 10'd0, 13'd64}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd1, 1'b1,
      '{STAT_ALIGN, 22'd0, 10'd0, 13'd64}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd0, 1'b1,
      '{STAT_OK, 22'd0, 10'd0, 13'd64}},
    // double release, then the same block handed out twice
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd0, 1'b0, '0},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b0, '0},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b0, '0},
    // zero size and a single block: exhaustion
    '{ROW_CFG, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b0, '0},
    '{ROW_CFG, CFG_BLOCK_COUNT, 13'd1, OP_ALLOC, 22'd0, 1'b0, '0},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b1, '{STAT_OK, 22'd0, 10'd0, 13'd8}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b1, '{STAT_OOM, 22'd0, 10'd0, 13'd8}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd8, 1'b1,
      '{STAT_RANGE, 22'd0, 10'd0, 13'd8}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd4, 1'b1,
      '{STAT_ALIGN, 22'd0, 10'd0, 13'd8}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd0, 1'b0, '0},
    // both registers saturated: 1024 blocks of 4096 bytes
    '{ROW_CFG, CFG_BLOCK_SIZE, 13'd8191, OP_ALLOC, 22'd0, 1'b0, '0},
    '{ROW_CFG, CFG_BLOCK_COUNT, 13'd2047, OP_ALLOC, 22'd0, 1'b0, '0},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b1,
      '{STAT_OK, 22'd0, 10'd0, 13'd4096}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd4190208, 1'b1,
      '{STAT_OK, 22'd0, 10'd1023, 13'd4096}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b1,
      '{STAT_OK, 22'd4190208, 10'd1023, 13'd4096}},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'h3FFFFF, 1'b1,
      '{STAT_ALIGN, 22'd0, 10'd0, 13'd4096}},
    // odd size rounded up, zero count
    '{ROW_CFG, CFG_BLOCK_SIZE, 13'd13, OP_ALLOC, 22'd0, 1'b0, '0},
    '{ROW_CFG, CFG_BLOCK_COUNT, 13'd0, OP_ALLOC, 22'd0, 1'b0, '0},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_ALLOC, 22'd0, 1'b0, '0},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd16, 1'b0, '0},
    '{ROW_ITEM, CFG_BLOCK_SIZE, 13'd0, OP_RELEASE, 22'd0, 1'b0, '0}
  };

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[fixed_block_free_list_allocator] ERROR");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result item: status %0d offset %0d index %0d bytes %0d",
                 out_status, out_block_offset, out_block_index, out_block_bytes);
          n_fail++;
        end else begin
          oldest = pending_results.pop_front();
          if (out_status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_status);
            n_fail++;
          end
          if (out_block_offset !== oldest.offset) begin
            $error("block_offset: expected %0d, got %0d", oldest.offset, out_block_offset);
            n_fail++;
          end
          if (out_block_index !== oldest.index) begin
            $error("block_index: expected %0d, got %0d", oldest.index, out_block_index);
            n_fail++;
          end
          if (out_block_bytes !== oldest.bytes) begin
            $error("block_bytes: expected %0d, got %0d", oldest.bytes, out_block_bytes);
            n_fail++;
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    alloc_result_t    got;
    logic [OPC_W-1:0] op;
    logic [OFF_W-1:0] off;
    int               bytes, count, r, k, v;
    logic [CFG_W-1:0] size_val, count_val;

    pool_size_reg  = SIZE_RST;
    pool_count_reg = COUNT_RST;
    stack_head     = EMPTY_MARK;
    fresh_next     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_DIR; i++) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        send_item(dir_rows[i].op, dir_rows[i].off, dir_rows[i].typed, dir_rows[i].res, got);
      end
    end

    // random phases, each with its own pool setting and idling and stall mode
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin size_val = 13'd8191; count_val = 13'd2047; end
        1: begin size_val = 13'd0; count_val = 13'd0; end
        2: begin
          size_val = CFG_W'($urandom_range(0, 8191));
          count_val = CFG_W'($urandom_range(1, 4));
        end
        3: begin size_val = 13'd4096; count_val = 13'd1024; end
        4: begin size_val = 13'd1; count_val = 13'd2; end
        5: begin
          size_val = CFG_W'($urandom_range(0, 8191));
          count_val = CFG_W'($urandom_range(0, 2047));
        end
        6: begin
          size_val = CFG_W'($urandom_range(1, 64));
          count_val = CFG_W'($urandom_range(1, 16));
        end
        default: begin
          size_val = CFG_W'($urandom_range(0, 8191));
          count_val = CFG_W'($urandom_range(0, 8));
        end
      endcase
      if ($urandom_range(1) == 0) begin
        write_reg(CFG_BLOCK_SIZE, size_val);
        write_reg(CFG_BLOCK_COUNT, count_val);
      end else begin
        write_reg(CFG_BLOCK_COUNT, count_val);
        write_reg(CFG_BLOCK_SIZE, size_val);
      end
      case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 78; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 78; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        bytes = block_bytes_eff();
        count = block_count_eff();
        off = OFF_W'($urandom);
        if ($urandom_range(99) < (granted_offsets.size() == 0 ? 75 : 50)) begin
          op = OP_ALLOC;
        end else begin
          op = OP_RELEASE;
          r = $urandom_range(99);
          if (r < 55 && granted_offsets.size() != 0) begin
            // give back a block that is out
            k = $urandom_range(granted_offsets.size() - 1);
            off = OFF_W'(granted_offsets[k]);
            granted_offsets.delete(k);
          end else if (r < 70) begin
            // aligned, in range, maybe never used or already free
            off = OFF_W'($urandom_range(count - 1) * bytes);
          end else if (r < 80) begin
            // just past the end of the pool
            v = bytes * count + $urandom_range(3);
            off = (v > OFF_LIMIT) ? OFF_W'(OFF_LIMIT) : OFF_W'(v);
          end else if (r < 90) begin
            // inside a block but not on its start
            off = OFF_W'($urandom_range(count - 1) * bytes + $urandom_range(1, bytes - 1));
          end
        end
        send_item(op, off, 1'b0, '0, got);
        if (op == OP_ALLOC && got.status == STAT_OK) granted_offsets.push_back(int'(got.offset));
      end
    end

    // drain
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("[fixed_block_free_list_allocator] OK");
    end else begin
      $display("[fixed_block_free_list_allocator] ERROR");
    end
    $finish;
  end

endmodule
